### rtl/ptr_pkg.sv
// shared types, constants and helpers for the prescaled timer
`default_nettype none

package ptr_pkg;

	localparam int unsigned CYC_W   = 8;   // elapsed cycle count width
	localparam int unsigned CNT_W   = 8;   // timer counter and divider width
	localparam int unsigned PRE_W   = 11;  // prescale count holds 1..1024
	localparam int unsigned ACC_W   = 8;   // divider accumulator stays below 255
	localparam int unsigned CFG_W   = 8;   // widest configuration register
	localparam int unsigned IDX_W   = 2;

	localparam logic [PRE_W-1:0] PERIOD_1024 = PRE_W'(1024);
	localparam logic [PRE_W-1:0] PERIOD_16   = PRE_W'(16);
	localparam logic [PRE_W-1:0] PERIOD_64   = PRE_W'(64);
	localparam logic [PRE_W-1:0] PERIOD_256  = PRE_W'(256);

	localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(8'hFF);
	localparam logic [ACC_W:0]     ACC_LIMIT = (ACC_W+1)'(9'h0FF);

	typedef enum logic [IDX_W-1:0] {
		REG_TIMER_ENABLE = 2'd0,
		REG_RATE_SELECT  = 2'd1,
		REG_RELOAD_VALUE = 2'd2,
		REG_UNUSED       = 2'd3
	} cfg_reg_idx_t;

	typedef struct packed {
		logic             timer_enable;
		logic [1:0]       rate_select;
		logic [CNT_W-1:0] reload_value;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] counter_value;
		logic [CNT_W-1:0] divider_value;
		logic             timer_irq;
	} result_t;

	function automatic logic [PRE_W-1:0] period_of(input logic [1:0] rate);
		logic [PRE_W-1:0] p;
		unique case (rate)
			2'd0:    p = PERIOD_1024;
			2'd1:    p = PERIOD_16;
			2'd2:    p = PERIOD_64;
			default: p = PERIOD_256;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

### rtl/ptr_core.sv
// timer state registers and the per-word step logic
`default_nettype none

module ptr_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [ptr_pkg::CYC_W-1:0]  cycles,
	input  wire ptr_pkg::cfg_t              cfg,
	output ptr_pkg::result_t                result
);
	import ptr_pkg::*;

	logic [PRE_W-1:0] prescale_q;
	logic [ACC_W-1:0] accum_q;
	logic [CNT_W-1:0] counter_q;
	logic [CNT_W-1:0] divider_q;

	logic [PRE_W-1:0] prescale_nxt;
	logic [ACC_W-1:0] accum_nxt;
	logic [CNT_W-1:0] counter_nxt;
	logic [CNT_W-1:0] divider_nxt;
	logic             irq_nxt;
	logic [ACC_W:0]   accum_sum;
	logic             expired;

	assign expired   = {{(PRE_W-CYC_W){1'b0}}, cycles} >= prescale_q;
	assign accum_sum = {1'b0, accum_q} + {{(ACC_W+1-CYC_W){1'b0}}, cycles};

	always_comb begin
		prescale_nxt = prescale_q;
		counter_nxt  = counter_q;
		irq_nxt      = 1'b0;
		if (cfg.timer_enable) begin
			if (expired) begin
				// reload period; counter advances once, excess dropped
				prescale_nxt = period_of(cfg.rate_select);
				if (counter_q == CNT_MAX) begin
					counter_nxt = cfg.reload_value;
					irq_nxt     = 1'b1;
				end else begin
					counter_nxt = counter_q + CNT_W'(1);
				end
			end else begin
				prescale_nxt = prescale_q - {{(PRE_W-CYC_W){1'b0}}, cycles};
			end
		end
		if (accum_sum >= ACC_LIMIT) begin
			accum_nxt   = '0;
			divider_nxt = divider_q + CNT_W'(1);
		end else begin
			accum_nxt   = accum_sum[ACC_W-1:0];
			divider_nxt = divider_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= PERIOD_1024;
			accum_q    <= '0;
			counter_q  <= '0;
			divider_q  <= '0;
		end else if (step) begin
			prescale_q <= prescale_nxt;
			accum_q    <= accum_nxt;
			counter_q  <= counter_nxt;
			divider_q  <= divider_nxt;
		end
	end

	assign result.counter_value = counter_nxt;
	assign result.divider_value = divider_nxt;
	assign result.timer_irq     = irq_nxt;

endmodule

`default_nettype wire

### rtl/prescaled_timer_with_reload.sv
// top level of the prescaled timer with divider and counter reload
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+---------------------------------
//  in      | to block  | in_valid / in_stall   | elapsed_cycles
//  out     | from block| out_valid / out_stall | counter_value, divider_value,
//          |           |                       | timer_irq
//  cfg     | to block  | cfg_write_en          | cfg_index, cfg_data
//
// one word in, one word out; an accepted word goes into the input register,
// then through the step logic into the result register, from which it leaves
// a new word is taken every cycle while the output side keeps moving
// the step logic runs once per word: adds, one subtract, compares
// reset clears the config registers, timer state and both valid flags;
// the prescale count comes up at 1024
// an output stall holds the result register and backs up into in_stall
`default_nettype none

module prescaled_timer_with_reload (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [ptr_pkg::CYC_W-1:0]  elapsed_cycles,
	// output channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [ptr_pkg::CNT_W-1:0]       counter_value,
	output logic [ptr_pkg::CNT_W-1:0]       divider_value,
	output logic                            timer_irq,
	// configuration write port
	input  wire logic                       cfg_write_en,
	input  wire logic [ptr_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [ptr_pkg::CFG_W-1:0]  cfg_data
);
	import ptr_pkg::*;

	cfg_t             cfg_q;
	logic             valid_s1;
	logic [CYC_W-1:0] cycles_s1;
	result_t          res_s2;
	logic             valid_s2;
	result_t          res_nxt;
	logic             advance;

	// configuration registers; index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_reg_idx_t'(cfg_index))
				REG_TIMER_ENABLE: cfg_q.timer_enable <= cfg_data[0];
				REG_RATE_SELECT:  cfg_q.rate_select  <= cfg_data[1:0];
				REG_RELOAD_VALUE: cfg_q.reload_value <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// word moves from the input register into the result register when
	// the result register is empty or being drained this cycle
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cycles_s1 <= elapsed_cycles;
		end
	end

	// state update happens only when the word actually leaves stage one
	ptr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cycles (cycles_s1),
		.cfg    (cfg_q),
		.result (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign counter_value = res_s2.counter_value;
	assign divider_value = res_s2.divider_value;
	assign timer_irq     = res_s2.timer_irq;

endmodule

`default_nettype wire
